>>> rtl/clu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clu_pkg
// Shared types, token codes and character tables of the C subset lexer.
// ----------------------------------------------------------------------------
package clu_pkg;

    localparam int LINE_WIDTH_DEF   = 20;
    localparam int COLUMN_WIDTH_DEF = 16;

    // kind, error code, value and length; line and column come on top
    localparam int KIND_W        = 6;
    localparam int ERR_W         = 3;
    localparam int LIT_W         = 31;
    localparam int LEN_W         = 8;
    localparam int TOK_FIXED_W   = KIND_W + ERR_W + LIT_W + LEN_W;

    // token queue depth, room for two tokens of one item is needed
    localparam int Q_DEPTH = 4;

    localparam logic [KIND_W-1:0] KIND_END     = 6'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 6'd2;
    localparam logic [KIND_W-1:0] KIND_CONST   = 6'd3;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd12;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd13;
    localparam logic [KIND_W-1:0] KIND_STAR    = 6'd14;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd15;
    localparam logic [KIND_W-1:0] KIND_PERCENT = 6'd16;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd17;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd18;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd19;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd20;
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 6'd21;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 6'd22;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 6'd23;
    localparam logic [KIND_W-1:0] KIND_NOT     = 6'd25;
    localparam logic [KIND_W-1:0] KIND_LT      = 6'd27;
    localparam logic [KIND_W-1:0] KIND_GT      = 6'd29;
    localparam logic [KIND_W-1:0] KIND_ANDAND  = 6'd31;
    localparam logic [KIND_W-1:0] KIND_OROR    = 6'd32;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 6'd33;
    localparam logic [KIND_W-1:0] KIND_NONE    = 6'd0;

    localparam logic [ERR_W-1:0] ERR_TOO_LARGE    = 3'd0;
    localparam logic [ERR_W-1:0] ERR_LONE_AMP     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_LONE_BAR     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR     = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OPEN_COMMENT = 3'd4;
    localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;

    localparam logic [7:0] CH_NEWLINE = 8'd10;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_PEND,
        MODE_LINEC,
        MODE_BLOCK,
        MODE_BLOCKSTAR,
        MODE_ERROR
    } t_mode;

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_EQ,
        PEND_BANG,
        PEND_LT,
        PEND_GT,
        PEND_AMP,
        PEND_BAR,
        PEND_SLASH
    } t_pend;

    // tokens written into the queue by one transfer
    typedef struct packed {
        logic slot0;
        logic slot1;
    } t_push;

    // keywords packed first byte lowest
    localparam int NUM_KW = 9;
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'h0000_0074_736E_6F63,   // const
        64'h0000_0000_0074_6E69,   // int
        64'h0000_0000_6469_6F76,   // void
        64'h0000_6E72_7574_6572,   // return
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6C65,   // else
        64'h0000_0065_6C69_6877,   // while
        64'h0000_006B_6165_7262,   // break
        64'h6575_6E69_746E_6F63    // continue
    };
    localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
        8'd5, 8'd3, 8'd4, 8'd6, 8'd2, 8'd4, 8'd5, 8'd5, 8'd8
    };

    function automatic logic [KIND_W-1:0] kw_kind(input logic [63:0] prefix,
                                                  input logic [LEN_W-1:0] count);
        logic [KIND_W-1:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if (count == KW_LEN[k] && prefix == KW_TEXT[k]) begin
                kind = KIND_CONST + KIND_W'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [KIND_W-1:0] single_op(input logic [7:0] c);
        logic [KIND_W-1:0] kind;
        case (c)
            "+":     kind = KIND_PLUS;
            "-":     kind = KIND_MINUS;
            "*":     kind = KIND_STAR;
            "%":     kind = KIND_PERCENT;
            ";":     kind = KIND_SEMI;
            ",":     kind = KIND_COMMA;
            "(":     kind = KIND_LPAREN;
            ")":     kind = KIND_RPAREN;
            "{":     kind = KIND_LBRACE;
            "}":     kind = KIND_RBRACE;
            default: kind = KIND_NONE;
        endcase
        return kind;
    endfunction

    function automatic t_pend pend_code(input logic [7:0] c);
        t_pend p;
        case (c)
            "=":     p = PEND_EQ;
            "!":     p = PEND_BANG;
            "<":     p = PEND_LT;
            ">":     p = PEND_GT;
            "&":     p = PEND_AMP;
            "|":     p = PEND_BAR;
            "/":     p = PEND_SLASH;
            default: p = PEND_NONE;
        endcase
        return p;
    endfunction

    // one-char kind of a pending comparison or assignment; plus one when '=' follows
    function automatic logic [KIND_W-1:0] pend_kind(input t_pend p);
        logic [KIND_W-1:0] kind;
        unique case (p)
            PEND_EQ:   kind = KIND_ASSIGN;
            PEND_BANG: kind = KIND_NOT;
            PEND_LT:   kind = KIND_LT;
            default:   kind = KIND_GT;
        endcase
        return kind;
    endfunction

endpackage
`default_nettype wire

>>> rtl/c_subset_lexer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_subset_lexer_unit
// Streaming lexer for a small C subset: one source byte in, tokens out.
// ----------------------------------------------------------------------------
//  channel   direction  payload                              tlast
//  s side    in         tdata[7:0] source byte                end of input
//  m side    out        tdata kind/err/value/line/col/len     last token of byte
//
//  one byte is taken per cycle while tready is high; the scanner state
//  updates in the cycle of the transfer and the tokens land in a four-entry
//  output queue. a byte yields zero, one or two tokens; tready drops while
//  fewer than two queue entries are free.
//  synchronous active-low reset returns the scanner to line 1, column 1.
// ----------------------------------------------------------------------------
module c_subset_lexer_unit
    import clu_pkg::*;
#(
    parameter int LINE_WIDTH   = LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF,
    parameter int TOK_W        = TOK_FIXED_W + LINE_WIDTH + COLUMN_WIDTH,
    parameter int TDATA_W      = ((TOK_W + 7) / 8) * 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,   // source_byte
    input  wire logic               i_s_tlast,   // end_of_input
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    // token_kind, error_code, number_value, token_line, token_column,
    // ident_length, zero pad
    output logic [TDATA_W-1:0]      o_m_tdata,
    output logic                    o_m_tlast    // last_of_run
);

    t_push          push;
    logic [TOK_W:0] tok0, tok1, q_entry;
    logic           fire;

    assign fire = i_s_tvalid && o_s_tready;

    clu_core #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH),
        .TOK_W        (TOK_W)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_byte     (i_s_tdata),
        .i_eoi_flag (i_s_tlast),
        .o_push     (push),
        .o_tok0     (tok0),
        .o_tok1     (tok1)
    );

    clu_queue #(
        .ENTRY_W (TOK_W + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok0  (tok0),
        .i_tok1  (tok1),
        .o_room  (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_entry (q_entry)
    );

    assign o_m_tdata = TDATA_W'(q_entry[TOK_W-1:0]);
    assign o_m_tlast = q_entry[TOK_W];

endmodule
`default_nettype wire

>>> rtl/clu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clu_core
// Scanner state and the per-byte step: up to two tokens for each byte.
// ----------------------------------------------------------------------------
module clu_core
    import clu_pkg::*;
#(
    parameter int LINE_WIDTH   = LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF,
    parameter int TOK_W        = TOK_FIXED_W + LINE_WIDTH + COLUMN_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_eoi_flag,
    output t_push                 o_push,
    output logic [TOK_W:0]        o_tok0,    // {last, token}
    output logic [TOK_W:0]        o_tok1
);

    localparam int LW = LINE_WIDTH;
    localparam int CW = COLUMN_WIDTH;

    t_mode              r_mode, n_mode;
    t_pend              r_pend, n_pend;
    logic [LW-1:0]      r_cur_line, n_cur_line, r_start_line, n_start_line;
    logic [CW-1:0]      r_cur_col, n_cur_col, r_start_col, n_start_col;
    logic [63:0]        r_prefix, n_prefix;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [LIT_W-1:0]   r_lit, n_lit;
    logic               r_ovf, n_ovf;

    function automatic logic [TOK_W-1:0] make_tok(input logic [KIND_W-1:0] kind,
                                                  input logic [ERR_W-1:0]  err,
                                                  input logic [LIT_W-1:0]  val,
                                                  input logic [LW-1:0]     ln,
                                                  input logic [CW-1:0]     col,
                                                  input logic [LEN_W-1:0]  len);
        return {len, col, ln, val, err, kind};
    endfunction

    // byte classes
    logic              eoi, is_alpha, is_digit, is_space, is_alnum, bad_char;
    logic [KIND_W-1:0] sop;
    t_pend             pcode;
    logic [3:0]        digit;

    assign eoi      = i_eoi_flag || (i_byte == 8'd0);
    assign is_alpha = (i_byte >= "a" && i_byte <= "z") || (i_byte >= "A" && i_byte <= "Z")
                      || i_byte == "_";
    assign is_digit = i_byte >= "0" && i_byte <= "9";
    assign is_space = i_byte == " " || (i_byte >= 8'd9 && i_byte <= 8'd13);
    assign is_alnum = is_alpha || is_digit;
    assign sop      = single_op(i_byte);
    assign pcode    = pend_code(i_byte);
    assign bad_char = !is_space && !is_alpha && !is_digit && sop == KIND_NONE
                      && pcode == PEND_NONE;
    assign digit    = i_byte[3:0];

    // position after this byte
    logic [LW-1:0] adv_line;
    logic [CW-1:0] adv_col;
    always_comb begin
        adv_line = r_cur_line;
        adv_col  = r_cur_col;
        if (i_byte == CH_NEWLINE) begin
            if (r_cur_line != '1) adv_line = r_cur_line + LW'(1);
            adv_col = CW'(1);
        end else if (r_cur_col != '1) begin
            adv_col = r_cur_col + CW'(1);
        end
    end

    // literal times ten plus digit
    logic [LIT_W+3:0] lit_next;
    assign lit_next = ({4'd0, r_lit} << 3) + ({4'd0, r_lit} << 1) + (LIT_W+4)'(digit);

    logic [KIND_W-1:0] kw;
    assign kw = kw_kind(r_prefix, r_count);

    // how the token in progress ends
    logic              f_emit, f_done, f_adv, f_to_error, f_end;
    logic [KIND_W-1:0] f_kind;
    logic [ERR_W-1:0]  f_err;
    logic [LIT_W-1:0]  f_val;
    logic [LEN_W-1:0]  f_len;
    logic              amp_bar, want_ok;

    assign amp_bar = r_pend == PEND_AMP || r_pend == PEND_BAR;
    assign want_ok = (r_pend == PEND_AMP) ? (i_byte == "&") : (i_byte == "|");

    always_comb begin
        f_emit     = 1'b0;
        f_done     = 1'b0;
        f_adv      = 1'b0;
        f_to_error = 1'b0;
        f_end      = 1'b0;
        f_kind     = KIND_NONE;
        f_err      = ERR_NONE;
        f_val      = '0;
        f_len      = '0;
        unique case (r_mode)
            MODE_ERROR: begin
                f_done = 1'b1;
                f_end  = eoi;
            end
            MODE_IDENT: begin
                if (!eoi && is_alnum) begin
                    f_done = 1'b1;
                    f_adv  = 1'b1;
                end else begin
                    f_emit = 1'b1;
                    f_kind = kw;
                    f_len  = r_count;
                end
            end
            MODE_NUMBER: begin
                if (!eoi && is_digit) begin
                    f_done = 1'b1;
                    f_adv  = 1'b1;
                end else if (r_ovf) begin
                    f_emit     = 1'b1;
                    f_kind     = KIND_ERROR;
                    f_err      = ERR_TOO_LARGE;
                    f_done     = 1'b1;
                    f_to_error = 1'b1;
                    f_end      = eoi;
                end else begin
                    f_emit = 1'b1;
                    f_kind = KIND_NUMBER;
                    f_val  = r_lit;
                end
            end
            MODE_PEND: begin
                if (amp_bar) begin
                    f_emit = 1'b1;
                    f_done = 1'b1;
                    if (!eoi && want_ok) begin
                        f_kind = (r_pend == PEND_AMP) ? KIND_ANDAND : KIND_OROR;
                        f_adv  = 1'b1;
                    end else begin
                        f_kind     = KIND_ERROR;
                        f_err      = (r_pend == PEND_AMP) ? ERR_LONE_AMP : ERR_LONE_BAR;
                        f_to_error = 1'b1;
                        f_end      = eoi;
                    end
                end else if (r_pend == PEND_SLASH) begin
                    if (!eoi && (i_byte == "/" || i_byte == "*")) begin
                        f_done = 1'b1;
                        f_adv  = 1'b1;
                    end else begin
                        f_emit = 1'b1;
                        f_kind = KIND_SLASH;
                    end
                end else begin
                    f_emit = 1'b1;
                    f_kind = pend_kind(r_pend);
                    if (!eoi && i_byte == "=") begin
                        f_kind = pend_kind(r_pend) + KIND_W'(1);
                        f_done = 1'b1;
                        f_adv  = 1'b1;
                    end
                end
            end
            MODE_LINEC: begin
                if (!eoi && i_byte != CH_NEWLINE) begin
                    f_done = 1'b1;
                    f_adv  = 1'b1;
                end
            end
            MODE_BLOCK, MODE_BLOCKSTAR: begin
                f_done = 1'b1;
                if (eoi) begin
                    f_emit = 1'b1;
                    f_kind = KIND_ERROR;
                    f_err  = ERR_OPEN_COMMENT;
                    f_end  = 1'b1;
                end else begin
                    f_adv = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // end token or a token started and finished by this byte
    logic end_now, s_valid;
    logic [TOK_W-1:0] s_tok, f_tok;

    assign end_now = f_end || (!f_done && eoi);
    assign f_tok   = make_tok(f_kind, f_err, f_val, r_start_line, r_start_col, f_len);

    always_comb begin
        s_valid = 1'b0;
        s_tok   = make_tok(KIND_END, ERR_NONE, '0, r_cur_line, r_cur_col, '0);
        if (end_now) begin
            s_valid = 1'b1;
        end else if (!f_done && sop != KIND_NONE) begin
            s_valid = 1'b1;
            s_tok   = make_tok(sop, ERR_NONE, '0, r_cur_line, r_cur_col, '0);
        end else if (!f_done && bad_char) begin
            s_valid = 1'b1;
            s_tok   = make_tok(KIND_ERROR, ERR_BAD_CHAR, '0, r_cur_line, r_cur_col, '0);
        end
    end

    // outputs to the queue
    always_comb begin
        o_push.slot0 = i_fire && (f_emit || s_valid);
        o_push.slot1 = i_fire && f_emit && s_valid;
        o_tok0       = f_emit ? {!s_valid, f_tok} : {1'b1, s_tok};
        o_tok1       = {1'b1, s_tok};
    end

    // next state
    always_comb begin
        n_mode       = r_mode;
        n_pend       = r_pend;
        n_cur_line   = r_cur_line;
        n_cur_col    = r_cur_col;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        n_prefix     = r_prefix;
        n_count      = r_count;
        n_lit        = r_lit;
        n_ovf        = r_ovf;
        if (!i_fire) begin
            // hold
        end else if (end_now) begin
            n_mode       = MODE_IDLE;
            n_pend       = PEND_NONE;
            n_cur_line   = LW'(1);
            n_cur_col    = CW'(1);
            n_start_line = LW'(1);
            n_start_col  = CW'(1);
            n_prefix     = '0;
            n_count      = '0;
            n_lit        = '0;
            n_ovf        = 1'b0;
        end else if (f_done) begin
            if (f_adv) begin
                n_cur_line = adv_line;
                n_cur_col  = adv_col;
            end
            unique case (r_mode)
                MODE_IDENT: begin
                    for (int i = 0; i < 8; i++) begin
                        if (r_count == LEN_W'(i)) n_prefix[8*i +: 8] = i_byte;
                    end
                    if (r_count != '1) n_count = r_count + LEN_W'(1);
                end
                MODE_NUMBER: begin
                    if (f_to_error) begin
                        n_mode = MODE_ERROR;
                    end else if (!r_ovf) begin
                        if (lit_next[LIT_W+3:LIT_W] != '0) n_ovf = 1'b1;
                        else n_lit = lit_next[LIT_W-1:0];
                    end
                end
                MODE_PEND: begin
                    if (f_to_error) n_mode = MODE_ERROR;
                    else if (r_pend == PEND_SLASH)
                        n_mode = (i_byte == "/") ? MODE_LINEC : MODE_BLOCK;
                    else n_mode = MODE_IDLE;
                end
                MODE_BLOCK, MODE_BLOCKSTAR: begin
                    if (r_mode == MODE_BLOCKSTAR && i_byte == "/") n_mode = MODE_IDLE;
                    else if (i_byte == "*") n_mode = MODE_BLOCKSTAR;
                    else n_mode = MODE_BLOCK;
                end
                default: begin
                end
            endcase
        end else begin
            // the byte starts something new
            n_mode       = MODE_IDLE;
            n_start_line = r_cur_line;
            n_start_col  = r_cur_col;
            if (!bad_char) begin
                n_cur_line = adv_line;
                n_cur_col  = adv_col;
            end
            if (is_alpha) begin
                n_mode   = MODE_IDENT;
                n_prefix = {56'd0, i_byte};
                n_count  = LEN_W'(1);
            end else if (is_digit) begin
                n_mode = MODE_NUMBER;
                n_lit  = LIT_W'(digit);
                n_ovf  = 1'b0;
            end else if (pcode != PEND_NONE) begin
                n_mode = MODE_PEND;
                n_pend = pcode;
            end else if (bad_char) begin
                n_mode = MODE_ERROR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_pend       <= PEND_NONE;
            r_cur_line   <= LW'(1);
            r_cur_col    <= CW'(1);
            r_start_line <= LW'(1);
            r_start_col  <= CW'(1);
            r_prefix     <= '0;
            r_count      <= '0;
            r_lit        <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_pend       <= n_pend;
            r_cur_line   <= n_cur_line;
            r_cur_col    <= n_cur_col;
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
            r_prefix     <= n_prefix;
            r_count      <= n_count;
            r_lit        <= n_lit;
            r_ovf        <= n_ovf;
        end
    end

endmodule
`default_nettype wire

>>> rtl/clu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clu_queue
// Small token queue: takes up to two tokens a cycle, hands out one while the reader is ready.
// ----------------------------------------------------------------------------
module clu_queue
    import clu_pkg::*;
#(
    parameter int ENTRY_W = TOK_FIXED_W + LINE_WIDTH_DEF + COLUMN_WIDTH_DEF + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_push                   i_push,
    input  wire logic [ENTRY_W-1:0] i_tok0,
    input  wire logic [ENTRY_W-1:0] i_tok1,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [ENTRY_W-1:0]      o_entry
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [ENTRY_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               pop;
    logic [PTR_W-1:0]   wp1;

    assign pop     = (r_cnt != '0) && i_ready;
    assign wp1     = r_wp + PTR_W'(1);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rp];
    assign o_room  = r_cnt <= CNT_W'(Q_DEPTH - 2);

    always_comb begin
        n_wp  = r_wp + PTR_W'(i_push.slot0) + PTR_W'(i_push.slot1);
        n_rp  = r_rp + PTR_W'(pop);
        n_cnt = r_cnt + CNT_W'(i_push.slot0) + CNT_W'(i_push.slot1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.slot0) r_mem[r_wp] <= i_tok0;
        if (i_push.slot1) r_mem[wp1]  <= i_tok1;
    end

endmodule
`default_nettype wire

>>> rtl/clu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clu_checker
// Port-level checks on the token stream of the lexer.
// ----------------------------------------------------------------------------
module clu_checker
    import clu_pkg::*;
#(
    parameter int TDATA_W = 88
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_m_tvalid,
    input wire logic               i_m_tready,
    input wire logic [TDATA_W-1:0] o_m_tdata,
    input wire logic               o_m_tlast
);

    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;

    assign kind = o_m_tdata[KIND_W-1:0];
    assign err  = o_m_tdata[KIND_W +: ERR_W];

    // queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("token valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("stalled token changed");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> kind <= KIND_ERROR)
        else $error("token kind out of range");

    a_err_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && kind != KIND_ERROR |-> err == ERR_NONE)
        else $error("error code on a non-error token");

    // the end token always closes the tokens of its byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && kind == KIND_END |-> o_m_tlast)
        else $error("end token not marked last");

endmodule

bind c_subset_lexer_unit clu_checker #(
    .TDATA_W (TDATA_W)
) u_clu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire
